// ===== src/ecas_pkg.sv =====
// Shared types and constants for the asynchronous elementary cellular automaton step block.
// No dependencies; every other file imports this package.
package ecas_pkg;

  localparam int ROW_BITS      = 64;
  localparam int DEF_MAX_CELLS = 64;
  localparam int CNT_W         = 7;
  localparam int WIDTH_W       = 7;
  localparam int RULE_W        = 8;
  localparam int RANK_W        = 32;
  localparam int PASS_W        = 4;
  localparam int PASS_COUNT    = 8;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 2;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

  localparam logic [REG_IDX_W-1:0] REG_RULE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RANK  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASS,
    ST_CNT1,
    ST_CNT2,
    ST_DONE
  } ecas_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [PASS_W-1:0] pass;
  } ecas_ctl_t;

endpackage

// ===== src/ecas_if.sv =====
// Request channels of the automaton step block: input requests and results.
// Depends on ecas_pkg for payload widths.
interface ecas_in_if import ecas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ROW_BITS-1:0] row_value;

  modport source (output valid, output mode, output row_value, input ready);
  modport sink   (input valid, input mode, input row_value, output ready);
endinterface

interface ecas_out_if import ecas_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row_out;
  logic [CNT_W-1:0]    ones_count;
  logic                still_conserved;

  modport source (output valid, output row_out, output ones_count, output still_conserved,
                  input ready);
  modport sink   (input valid, input row_out, input ones_count, input still_conserved,
                  output ready);
endinterface

// ===== src/ecas_cell.sv =====
// One cell of the automaton row: holds its state bit and applies the rule in its pass.
// Depends on ecas_pkg for the control struct and widths.
module ecas_cell import ecas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ecas_ctl_t         ctl,
  input  logic [RULE_W-1:0] rule,
  input  logic [RANK_W-1:0] rank_table,
  input  logic              active,
  input  logic              load_bit,
  input  logic              left_bit,
  input  logic              right_bit,
  output logic              state_bit
);

  logic        state_r;
  logic        state_nxt;
  logic [2:0]  pat;
  logic [PASS_W-1:0] rank;

  assign pat  = {left_bit, state_r, right_bit};
  assign rank = rank_table[{pat, 2'b00} +: PASS_W];

  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = load_bit & active;
    end else if (ctl.step) begin
      if (!active) begin
        state_nxt = 1'b0;
      end else if (rank == ctl.pass) begin
        state_nxt = rule[pat];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state_bit = state_r;

endmodule

// ===== src/ecas_row.sv =====
// Cyclic chain of cells; wires each cell to its neighbors for the live width.
// Depends on ecas_pkg and ecas_cell.
module ecas_row import ecas_pkg::*; #(
  parameter int CELLS = DEF_MAX_CELLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ecas_ctl_t          ctl,
  input  logic [RULE_W-1:0]  rule,
  input  logic [RANK_W-1:0]  rank_table,
  input  logic [WIDTH_W-1:0] live_w,
  input  logic [CELLS-1:0]   load_row,
  output logic [CELLS-1:0]   row
);

  localparam int IDX_W = $clog2(CELLS);

  logic [WIDTH_W-1:0] last_w;
  logic [IDX_W-1:0]   last_idx;
  logic               wrap_bit;

  assign last_w   = live_w - WIDTH_W'(1);
  assign last_idx = last_w[IDX_W-1:0];
  assign wrap_bit = row[last_idx];

  for (genvar x = 0; x < CELLS; x++) begin : g_cell
    logic active;
    logic is_last;
    logic left_bit;
    logic right_bit;

    assign active  = WIDTH_W'(x) < live_w;
    assign is_last = WIDTH_W'(x) == last_w;

    if (x == 0) begin : g_first
      assign left_bit = wrap_bit;
    end else begin : g_inner
      assign left_bit = row[x-1];
    end

    if (x == CELLS - 1) begin : g_end
      assign right_bit = row[0];
    end else begin : g_mid
      assign right_bit = is_last ? row[0] : row[x+1];
    end

    ecas_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .rule       (rule),
      .rank_table (rank_table),
      .active     (active),
      .load_bit   (load_row[x]),
      .left_bit   (left_bit),
      .right_bit  (right_bit),
      .state_bit  (row[x])
    );
  end

endmodule

// ===== src/ecas_popcount.sv =====
// Two-stage registered count of ones in the row: byte counts, then their sum.
// Depends on ecas_pkg for widths.
module ecas_popcount import ecas_pkg::*; (
  input  logic                clk,
  input  logic [ROW_BITS-1:0] row,
  output logic [CNT_W-1:0]    count
);

  localparam int GROUPS = ROW_BITS / 8;
  localparam int GRP_W  = 4;

  logic [GRP_W-1:0] part_r [GROUPS];
  logic [GRP_W-1:0] part_nxt [GROUPS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        part_nxt[g] = part_nxt[g] + GRP_W'(row[g*8+b]);
      end
    end
  end

  always_comb begin
    count_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      count_nxt = count_nxt + CNT_W'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    part_r  <= part_nxt;
    count_r <= count_nxt;
  end

  assign count = count_r;

endmodule

// ===== src/async_elementary_ca_step.sv =====
// Top level of the asynchronous elementary cellular automaton step block.
// Depends on ecas_pkg, ecas_if, ecas_row, ecas_cell and ecas_popcount.
//
//   channel  | direction | handshake          | payload
//   in_ch    | sink      | valid / ready      | mode, row_value
//   out_ch   | source    | valid / ready      | row_out, ones_count, still_conserved
//   config   | APB slave | psel/penable/pready| paddr, pwdata, prdata
//
// A load request passes through ST_CNT1, ST_CNT2 and ST_DONE before the next acceptance,
// a step request first through eight update passes of the cell chain, one per cycle, then
// the same count states; ST_DONE registers the result. One request is in work at a time.
// A result waiting on out_ch does not block acceptance of the next request; ST_DONE waits.
// Reset is synchronous, active low; clears row, rule, rank, control state; no clearing pass.
module async_elementary_ca_step import ecas_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS
) (
  input  logic               clk,
  input  logic               rst_n,
  ecas_in_if.sink            in_ch,
  ecas_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CELLS = (MAX_CELLS < ROW_BITS) ? MAX_CELLS : ROW_BITS;

  logic [RULE_W-1:0]    rule_r;
  logic [RANK_W-1:0]    rank_r;
  logic [WIDTH_W-1:0]   width_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [WIDTH_W-1:0]   live_w;

  ecas_state_t          state_r, state_nxt;
  logic [PASS_W-1:0]    pass_r, pass_nxt;
  logic                 mode_r, mode_nxt;
  logic [CNT_W-1:0]     init_ones_r, init_ones_nxt;
  logic                 flag_r, flag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_BITS-1:0]  out_row_r, out_row_nxt;
  logic [CNT_W-1:0]     out_ones_r, out_ones_nxt;
  logic                 out_cons_r, out_cons_nxt;

  ecas_ctl_t            ctl;
  logic                 accept;
  logic [CELLS-1:0]     row;
  logic [ROW_BITS-1:0]  row_full;
  logic [CNT_W-1:0]     ones;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_RULE:  prdata = PDATA_W'(rule_r);
      REG_RANK:  prdata = rank_r;
      REG_WIDTH: prdata = PDATA_W'(width_r);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_r  <= '0;
      rank_r  <= '0;
      width_r <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RULE:  rule_r  <= pwdata[RULE_W-1:0];
        REG_RANK:  rank_r  <= pwdata[RANK_W-1:0];
        REG_WIDTH: width_r <= pwdata[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      live_w = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(CELLS)) begin
      live_w = WIDTH_W'(CELLS);
    end else begin
      live_w = width_r;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign row_full    = ROW_BITS'(row);

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    mode_nxt      = mode_r;
    init_ones_nxt = init_ones_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_ones_nxt  = out_ones_r;
    out_cons_nxt  = out_cons_r;
    ctl.load      = 1'b0;
    ctl.step      = 1'b0;
    ctl.pass      = pass_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt = in_ch.mode;
          pass_nxt = PASS_W'(1);
          if (in_ch.mode == MODE_LOAD) begin
            ctl.load  = 1'b1;
            state_nxt = ST_CNT1;
          end else begin
            state_nxt = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        ctl.step = 1'b1;
        pass_nxt = pass_r + PASS_W'(1);
        if (pass_r == PASS_W'(PASS_COUNT)) begin
          state_nxt = ST_CNT1;
        end
      end
      ST_CNT1: begin
        state_nxt = ST_CNT2;
      end
      ST_CNT2: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          if (mode_r == MODE_LOAD) begin
            init_ones_nxt = ones;
            flag_nxt      = 1'b1;
            out_cons_nxt  = 1'b1;
          end else begin
            flag_nxt     = flag_r && (ones == init_ones_r);
            out_cons_nxt = flag_r && (ones == init_ones_r);
          end
          out_row_nxt   = row_full;
          out_ones_nxt  = ones;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pass_r      <= '0;
      mode_r      <= MODE_LOAD;
      init_ones_r <= '0;
      flag_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      mode_r      <= mode_nxt;
      init_ones_r <= init_ones_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r  <= out_row_nxt;
    out_ones_r <= out_ones_nxt;
    out_cons_r <= out_cons_nxt;
  end

  ecas_row #(
    .CELLS (CELLS)
  ) u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rule       (rule_r),
    .rank_table (rank_r),
    .live_w     (live_w),
    .load_row   (in_ch.row_value[CELLS-1:0]),
    .row        (row)
  );

  ecas_popcount u_popcount (
    .clk   (clk),
    .row   (row_full),
    .count (ones)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.row_out         = out_row_r;
  assign out_ch.ones_count      = out_ones_r;
  assign out_ch.still_conserved = out_cons_r;

endmodule

// ===== src/ecas_checker.sv =====
// Port-level checks for the automaton step block, attached to the top level by bind.
// Depends on ecas_pkg for widths.
module ecas_checker import ecas_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ROW_BITS-1:0] row_out,
  input logic [CNT_W-1:0]    ones_count,
  input logic                still_conserved
);

  localparam logic [CNT_W-1:0] MAX_ONES = CNT_W'(ROW_BITS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result was withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(row_out) && $stable(ones_count) && $stable(still_conserved))
    else $error("Result payload changed while stalled.");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second request was accepted while one is in work.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ones_count <= MAX_ONES)
    else $error("Count of ones exceeds the row width.");

endmodule

bind async_elementary_ca_step ecas_checker u_ecas_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .row_out         (out_ch.row_out),
  .ones_count      (out_ch.ones_count),
  .still_conserved (out_ch.still_conserved)
);
